@@ hdl/bfm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants of the 3x3 box mean filter
// Frame size limits, register map, beat payloads and the structs that
// travel between the filter's modules.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Field and register widths.
  localparam int PIX_W  = 8;
  localparam int SIZE_W = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int CSUM_W = PIX_W + 2;
  localparam int SUM_W  = PIX_W + 4;
  localparam int LINE_W = 2 * PIX_W;

  // Division by nine as a multiply by a rounded-up reciprocal.
  localparam int               RECIP_SHIFT = 16;
  localparam int               RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
  localparam int               PROD_W      = SUM_W + RECIP_W;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;
  localparam logic [SIZE_W-1:0] RESET_FRAME_WIDTH  = 11'd24;
  localparam logic [SIZE_W-1:0] RESET_FRAME_HEIGHT = 11'd7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             pad_item;
  } pix_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean_value;
    logic             frame_end;
  } mean_beat_t;

  // Effective frame size plus a restart strobe on every register write.
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              restart;
  } cfg_t;

  // Per-item control decoded when the pixel is taken in.
  typedef struct packed {
    logic             wrap;
    logic             last;
    logic             norm;
    logic             col_ge2;
    logic             row_ge1;
    logic             row_ge2;
    logic             width_ge2;
    logic [PIX_W-1:0] pixel;
  } item_ctrl_t;

  // Neighbourhood sum waiting for the divider.
  typedef struct packed {
    logic             hit;
    logic [SUM_W-1:0] sum;
    logic             last;
  } win_res_t;

endpackage

@@ hdl/bfm_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfm_cfg: configuration registers
// Holds frame width and height, serves APB reads and clamps the sizes to
// the supported range.
// ----------------------------------------------------------------------------
module bfm_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bfm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bfm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bfm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output bfm_pkg::cfg_t                      cfg_o
);

  logic [bfm_pkg::SIZE_W-1:0] width_q, width_d;
  logic [bfm_pkg::SIZE_W-1:0] height_q, height_d;
  logic                       wr_en;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (reg_sel)
        bfm_pkg::REG_FRAME_WIDTH:  width_d  = pwdata[bfm_pkg::SIZE_W-1:0];
        bfm_pkg::REG_FRAME_HEIGHT: height_d = pwdata[bfm_pkg::SIZE_W-1:0];
        default:                   width_d  = width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bfm_pkg::RESET_FRAME_WIDTH;
      height_q <= bfm_pkg::RESET_FRAME_HEIGHT;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      bfm_pkg::REG_FRAME_WIDTH:  prdata[bfm_pkg::SIZE_W-1:0] = width_q;
      bfm_pkg::REG_FRAME_HEIGHT: prdata[bfm_pkg::SIZE_W-1:0] = height_q;
      default:                   prdata = '0;
    endcase
  end

  // A size of zero counts as one, anything above the maximum as the maximum.
  always_comb begin
    if (width_q == '0) begin
      cfg_o.width = bfm_pkg::SIZE_W'(1);
    end else if (width_q > bfm_pkg::SIZE_W'(bfm_pkg::MAX_WIDTH)) begin
      cfg_o.width = bfm_pkg::SIZE_W'(bfm_pkg::MAX_WIDTH);
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q == '0) begin
      cfg_o.height = bfm_pkg::SIZE_W'(1);
    end else if (height_q > bfm_pkg::SIZE_W'(bfm_pkg::MAX_HEIGHT)) begin
      cfg_o.height = bfm_pkg::SIZE_W'(bfm_pkg::MAX_HEIGHT);
    end else begin
      cfg_o.height = height_q;
    end
    cfg_o.restart = wr_en;
  end

endmodule

@@ hdl/bfm_line_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfm_line_mem: line store memory with write forwarding
// One entry per column holds the upper and middle row pixels. One read and
// one write per cycle; a read of the entry written in the same cycle gets
// the new data.
// ----------------------------------------------------------------------------
module bfm_line_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        re_i,
  input  logic [bfm_pkg::COL_W-1:0]   raddr_i,
  input  logic                        we_i,
  input  logic [bfm_pkg::COL_W-1:0]   waddr_i,
  input  logic [bfm_pkg::LINE_W-1:0]  wdata_i,
  output logic [bfm_pkg::LINE_W-1:0]  rdata_o
);

  logic [bfm_pkg::LINE_W-1:0] mem_q [bfm_pkg::MAX_WIDTH];
  logic [bfm_pkg::LINE_W-1:0] rdata_q;
  logic [bfm_pkg::LINE_W-1:0] fwd_data_q;
  logic                       fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q    <= mem_q[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  // The array reads old data on a collision, so the written word is kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (re_i) begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

@@ hdl/bfm_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfm_window: 3x3 window and neighbourhood sum
// Shifts in one column per item and forms the sum for either the pixel one
// column back or, at a row wrap, the last pixel of the row before.
// ----------------------------------------------------------------------------
module bfm_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  bfm_pkg::item_ctrl_t         ctrl_i,
  input  logic [bfm_pkg::LINE_W-1:0]  line_i,
  output logic [bfm_pkg::PIX_W-1:0]   middle_o,
  output bfm_pkg::win_res_t           res_o
);

  // Window rows top to bottom, columns oldest to newest.
  logic [bfm_pkg::PIX_W-1:0]  win_q [3][3];
  logic [bfm_pkg::PIX_W-1:0]  upper, middle;
  logic [bfm_pkg::PIX_W-1:0]  new_col [3];
  logic [bfm_pkg::CSUM_W-1:0] cs0, cs1, cs2, cs_new;
  logic [bfm_pkg::SUM_W-1:0]  wrap_sum, norm_sum;

  assign middle_o = line_i[bfm_pkg::PIX_W-1:0];
  assign upper    = ctrl_i.row_ge2 ? line_i[bfm_pkg::LINE_W-1:bfm_pkg::PIX_W] : '0;
  assign middle   = ctrl_i.row_ge1 ? line_i[bfm_pkg::PIX_W-1:0] : '0;

  assign new_col[0] = upper;
  assign new_col[1] = middle;
  assign new_col[2] = ctrl_i.pixel;

  assign cs0 = bfm_pkg::CSUM_W'(win_q[0][0]) + bfm_pkg::CSUM_W'(win_q[1][0])
             + bfm_pkg::CSUM_W'(win_q[2][0]);
  assign cs1 = bfm_pkg::CSUM_W'(win_q[0][1]) + bfm_pkg::CSUM_W'(win_q[1][1])
             + bfm_pkg::CSUM_W'(win_q[2][1]);
  assign cs2 = bfm_pkg::CSUM_W'(win_q[0][2]) + bfm_pkg::CSUM_W'(win_q[1][2])
             + bfm_pkg::CSUM_W'(win_q[2][2]);
  assign cs_new = bfm_pkg::CSUM_W'(upper) + bfm_pkg::CSUM_W'(middle)
                + bfm_pkg::CSUM_W'(ctrl_i.pixel);

  // At a row wrap the window still holds the last two columns of the row and
  // the column to the right lies outside the frame.
  assign wrap_sum = bfm_pkg::SUM_W'(cs2)
                  + (ctrl_i.width_ge2 ? bfm_pkg::SUM_W'(cs1) : '0);
  // Otherwise the sum is over the window after the shift.
  assign norm_sum = bfm_pkg::SUM_W'(cs2) + bfm_pkg::SUM_W'(cs_new)
                  + (ctrl_i.col_ge2 ? bfm_pkg::SUM_W'(cs1) : '0);

  always_comb begin
    res_o.hit  = ctrl_i.wrap || ctrl_i.norm;
    res_o.sum  = ctrl_i.wrap ? wrap_sum : norm_sum;
    res_o.last = ctrl_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
        win_q[i][2] <= new_col[i];
      end
    end
  end

endmodule

@@ hdl/bfm_div9.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfm_div9: divide by nine and output register
// Turns a neighbourhood sum into its truncated mean and holds the result
// beat until the receiver takes it.
// ----------------------------------------------------------------------------
module bfm_div9 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [bfm_pkg::SUM_W-1:0]  sum_i,
  input  logic                       last_i,
  output logic                       ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bfm_pkg::mean_beat_t        out_data_o
);

  logic [bfm_pkg::PROD_W-1:0] prod;
  logic                       load;
  logic                       out_valid_q, out_valid_d;
  bfm_pkg::mean_beat_t        out_data_q;

  // The reciprocal error stays below one ninth over the full sum range.
  assign prod    = bfm_pkg::PROD_W'(sum_i) * bfm_pkg::PROD_W'(bfm_pkg::RECIP_NINE);
  assign ready_o = !out_valid_q || !out_stall_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.mean_value <= prod[bfm_pkg::RECIP_SHIFT +: bfm_pkg::PIX_W];
      out_data_q.frame_end  <= last_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ hdl/box_filter_3x3_mean.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_mean: streaming 3x3 box mean filter, zero padded
// Raster-order grey pixels in, truncated 3x3 neighbourhood means out.
// ----------------------------------------------------------------------------
// The filter takes one pixel beat per clock unless in_stall_o is high and
// gives one mean beat per pixel of the frame, each trailing its pixel by
// one row plus one pixel of input, so after the last pixel of a frame the
// source sends frame_width+1 beats with pad_item set to push the final
// results out; frame_end marks the result for the last pixel, after which
// the next beat starts a new frame. The sustained rate without stalls is
// one beat per clock, set by the line store memory, which is read once and
// written once per beat: each beat reads its column's entry when taken and
// writes it back as it leaves the memory stage, with forwarding when the
// next beat hits the same column (frame width one). A mean goes through the
// memory stage, sum stage and divider output registers. The line stores
// need no clearing pass after reset: rows not yet seen are masked by the
// row counter. Writing either size register restarts the frame; it is to
// be done only while the filter is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module box_filter_3x3_mean (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Pixel stream.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bfm_pkg::pix_beat_t                 in_data_i,
  // Mean stream.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bfm_pkg::mean_beat_t                out_data_o,
  // Configuration.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bfm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bfm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bfm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  bfm_pkg::cfg_t cfg;

  bfm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // --------------------------------------------------------------------------
  // Intake: position counters and per-item decode.
  // --------------------------------------------------------------------------
  logic [bfm_pkg::COL_W-1:0]  col_q, col_d;
  logic [bfm_pkg::ROW_W-1:0]  row_q, row_d;
  logic [bfm_pkg::COL_W-1:0]  col_eff;
  logic [bfm_pkg::SIZE_W-1:0] col_inc;
  logic [bfm_pkg::ROW_W-1:0]  row_inc;
  logic [bfm_pkg::ROW_W-1:0]  row_next;
  logic [bfm_pkg::ROW_W-1:0]  last_row;
  logic [bfm_pkg::ROW_W-1:0]  height_ext;
  logic                       col_zero;
  logic                       accept;
  bfm_pkg::item_ctrl_t        ctrl0;

  assign accept     = in_valid_i && !in_stall_o;
  assign height_ext = bfm_pkg::ROW_W'(cfg.height);
  // Second drain row below the frame; its first column closes the frame.
  assign last_row   = height_ext + bfm_pkg::ROW_W'(1);

  assign col_eff  = (bfm_pkg::SIZE_W'(col_q) >= cfg.width) ? '0 : col_q;
  assign col_zero = (col_eff == '0);

  always_comb begin
    ctrl0.pixel     = (!in_data_i.pad_item && (row_q < height_ext))
                      ? in_data_i.pixel_value : '0;
    ctrl0.row_ge1   = (row_q != '0);
    ctrl0.row_ge2   = (row_q >= bfm_pkg::ROW_W'(2));
    ctrl0.col_ge2   = (col_eff >= bfm_pkg::COL_W'(2));
    ctrl0.width_ge2 = (cfg.width >= bfm_pkg::SIZE_W'(2));
    ctrl0.wrap      = col_zero && ctrl0.row_ge2;
    ctrl0.last      = ctrl0.wrap && (row_q == last_row);
    ctrl0.norm      = !col_zero && ctrl0.row_ge1 && (row_q <= height_ext);
  end

  assign col_inc = bfm_pkg::SIZE_W'(col_eff) + bfm_pkg::SIZE_W'(1);
  assign row_inc = row_q + bfm_pkg::ROW_W'(1);

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    row_next = row_q;
    if (cfg.restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (ctrl0.last) begin
        col_d = '0;
        row_d = '0;
      end else begin
        if (col_inc >= cfg.width) begin
          col_d    = '0;
          row_next = row_inc;
        end else begin
          col_d    = col_inc[bfm_pkg::COL_W-1:0];
          row_next = row_q;
        end
        if (row_next > last_row) begin
          col_d = '0;
          row_d = '0;
        end else begin
          row_d = row_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Memory stage: the line store read issued at intake returns here, the
  // window shifts and the column entry is written back.
  // --------------------------------------------------------------------------
  logic                        s1_valid_q, s1_valid_d;
  bfm_pkg::item_ctrl_t         s1_ctrl_q;
  logic [bfm_pkg::COL_W-1:0]   s1_col_q;
  logic                        s1_ready;
  logic                        s1_adv;
  logic [bfm_pkg::LINE_W-1:0]  line_rdata;
  logic [bfm_pkg::PIX_W-1:0]   line_middle;
  logic [bfm_pkg::LINE_W-1:0]  line_wdata;
  bfm_pkg::win_res_t           win_res;

  logic                        s2_valid_q, s2_valid_d;
  bfm_pkg::win_res_t           s2_res_q;
  logic                        s2_ready;
  logic                        s2_adv;

  assign s1_ready   = !s2_valid_q || s2_ready;
  assign s1_adv     = s1_valid_q && s1_ready;
  assign in_stall_o = s1_valid_q && !s1_ready;

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctrl_q <= ctrl0;
      s1_col_q  <= col_eff;
    end
  end

  // The middle row entry moves up and the new pixel becomes the middle row.
  assign line_wdata = {line_middle, s1_ctrl_q.pixel};

  bfm_line_mem u_line_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (col_eff),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (line_wdata),
    .rdata_o (line_rdata)
  );

  bfm_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .ctrl_i   (s1_ctrl_q),
    .line_i   (line_rdata),
    .middle_o (line_middle),
    .res_o    (win_res)
  );

  // --------------------------------------------------------------------------
  // Sum stage: only items that produce a result enter it.
  // --------------------------------------------------------------------------
  assign s2_adv = s2_valid_q && s2_ready;

  always_comb begin
    if (s1_adv && win_res.hit) begin
      s2_valid_d = 1'b1;
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
    end else begin
      s2_valid_d = s2_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && win_res.hit) begin
      s2_res_q <= win_res;
    end
  end

  bfm_div9 u_div9 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s2_valid_q),
    .sum_i       (s2_res_q.sum),
    .last_i      (s2_res_q.last),
    .ready_o     (s2_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ dv/bfm_mean_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfm_mean_checker: scoreboard for the 3x3 box mean filter
// Follows size register writes and accepted pixel beats, predicts every mean
// beat and compares it with the next mean beat the filter hands out.
// ----------------------------------------------------------------------------
module bfm_mean_checker
  import bfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  pix_beat_t             in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  mean_beat_t            out_data_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam int unsigned NEIGHBOURHOOD = 9;
  localparam int          PRINT_LIMIT   = 40;
  localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};

  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [PIX_W-1:0]  upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0]  middle_line [MAX_WIDTH];
  // Row-major 3x3 window, column 2 holds the newest column.
  logic [PIX_W-1:0]  window [9];
  int unsigned       col;
  int unsigned       row;
  mean_beat_t        expected_means [$];
  mean_beat_t        predicted;
  mean_beat_t        want;

  function automatic int unsigned effective_size(input logic [SIZE_W-1:0] v,
                                                 input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic int unsigned column_total(input int k);
    return int'(window[k]) + int'(window[3 + k]) + int'(window[6 + k]);
  endfunction

  // Advances the filter state by one pixel beat. Returns 1 when the beat
  // pushes out a mean, which is then left in res.
  function automatic bit filter_pixel(input pix_beat_t pix, output mean_beat_t res);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned x;
    int unsigned u;
    int unsigned m;
    int unsigned sum;
    bit          hit;
    bit          last;
    w    = effective_size(width_reg, MAX_WIDTH);
    h    = effective_size(height_reg, MAX_HEIGHT);
    c    = (col >= w) ? 0 : col;
    r    = row;
    hit  = 1'b0;
    last = 1'b0;
    sum  = 0;
    x = (!pix.pad_item && r < h) ? pix.pixel_value : 0;
    u = (r >= 2) ? upper_line[c] : 0;
    m = (r >= 1) ? middle_line[c] : 0;
    upper_line[c]  = middle_line[c];
    middle_line[c] = PIX_W'(x);

    // Entering column 0 completes the last pixel of the row two above,
    // whose right neighbours lie outside the frame.
    if (c == 0 && r >= 2) begin
      hit  = 1'b1;
      sum  = column_total(2) + ((w >= 2) ? column_total(1) : 0);
      last = (r == h + 1);
    end

    for (int k = 0; k < 3; k++) begin
      window[3 * k]     = window[3 * k + 1];
      window[3 * k + 1] = window[3 * k + 2];
    end
    window[2] = PIX_W'(u);
    window[5] = PIX_W'(m);
    window[8] = PIX_W'(x);

    if (c >= 1 && r >= 1 && r <= h) begin
      hit = 1'b1;
      sum = column_total(1) + column_total(2) + ((c >= 2) ? column_total(0) : 0);
    end

    if (last) begin
      col = 0;
      row = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r > h + 1) begin
        r = 0;
        c = 0;
      end
      col = c;
      row = r;
    end

    res.mean_value = PIX_W'(sum / NEIGHBOURHOOD);
    res.frame_end  = last;
    return hit;
  endfunction

  task automatic report(input string msg);
    if (errors_o < PRINT_LIMIT) $display("%0t: mismatch: %s", $time, msg);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = RESET_FRAME_WIDTH;
      height_reg = RESET_FRAME_HEIGHT;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      col = 0;
      row = 0;
      expected_means.delete();
      errors_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == WIDTH_ADDR) begin
          width_reg = pwdata_i[SIZE_W-1:0];
          col = 0;
          row = 0;
        end else if (paddr_i == HEIGHT_ADDR) begin
          height_reg = pwdata_i[SIZE_W-1:0];
          col = 0;
          row = 0;
        end
      end

      // The output side is compared first, so a mean beat can never be
      // matched against a prediction made at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_means.size() == 0) begin
          report($sformatf("mean beat %0d with nothing expected", out_data_i.mean_value));
        end else begin
          want = expected_means.pop_front();
          if (out_data_i.mean_value !== want.mean_value)
            report($sformatf("mean_value %0d, expected %0d",
                             out_data_i.mean_value, want.mean_value));
          if (out_data_i.frame_end !== want.frame_end)
            report($sformatf("frame_end %0b, expected %0b",
                             out_data_i.frame_end, want.frame_end));
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (filter_pixel(in_data_i, predicted)) expected_means.push_back(predicted);
      end
    end
    pending_o = expected_means.size();
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the 3x3 box mean filter
// Streams pixel frames of many sizes through the filter with random gaps and
// random output stalls; a separate scoreboard predicts and checks every mean.
// ----------------------------------------------------------------------------
module tb;
  import bfm_pkg::*;

  // The limit is set many times above the slowest legal run.
  localparam int LIMIT_CYCLES  = 600000;
  // Long receiver hold-off that fills the filter and backs up the input.
  localparam int HOLD_CYCLES   = 300;
  // Quiet time after the last expected mean, long enough for any beat still
  // in flight to leave the filter.
  localparam int SETTLE_CYCLES = 10;
  // Pixel beats of the whole run, directed ones included.
  localparam int ITEMS_TOTAL   = 1950;
  localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  pix_beat_t             in_data;
  logic                  out_valid;
  logic                  out_stall;
  mean_beat_t            out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int errors;
  int outstanding;
  int cycle_count = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  // Effective frame size as the filter sees it, used to shape the frames.
  int frame_w     = RESET_FRAME_WIDTH;
  int frame_h     = RESET_FRAME_HEIGHT;
  bit hold_req    = 1'b0;

  box_filter_3x3_mean dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  bfm_mean_checker mean_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .errors_o    (errors),
    .pending_o   (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: a hung handshake or a lost mean ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver. The stall pattern changes from one random stretch to the next,
  // including stretches with no stall at all. When the stimulus raises
  // hold_req, the receiver refuses every mean beat through a hold-off so
  // that the filter's pipeline fills and its input stall must come up.
  initial begin : receiver
    stall_mode_e mode;
    int          stretch;
    out_stall = 1'b0;
    forever begin
      mode    = stall_mode_e'($urandom_range(0, 3));
      stretch = $urandom_range(20, 200);
      for (int k = 0; k < stretch; k++) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= ((k % 5) < 2);
        endcase
      end
    end
  end

  function automatic int effective_size(input logic [SIZE_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic pix_beat_t pixel_beat(input logic [PIX_W-1:0] v, input logic pad);
    pix_beat_t b;
    b.pixel_value = v;
    b.pad_item    = pad;
    return b;
  endfunction

  // A pixel inside the frame: the grey extremes are favored, and now and
  // then a pad beat lands inside the frame, where it counts as black.
  function automatic pix_beat_t frame_pixel();
    pix_beat_t b;
    if ($urandom_range(0, 6) == 0) b.pixel_value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    else b.pixel_value = PIX_W'($urandom);
    b.pad_item = ($urandom_range(0, 19) == 0);
    return b;
  endfunction

  // A drain beat after the frame; some carry a plain pixel, which the filter
  // must treat like a pad beat.
  function automatic pix_beat_t drain_beat();
    return pixel_beat(PIX_W'($urandom), $urandom_range(0, 9) != 0);
  endfunction

  // Mostly small sizes so that frames stay short, sometimes zero (which the
  // filter reads as one), sometimes with junk in the unused upper bits.
  function automatic logic [APB_DATA_W-1:0] random_size(input int top_value);
    logic [APB_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = $urandom_range(9, top_value);
      default: v = $urandom_range(1, 8);
    endcase
    if ($urandom_range(0, 4) == 0) v = v | ($urandom & ~APB_DATA_W'((1 << SIZE_W) - 1));
    return v;
  endfunction

  // Offers one pixel beat and returns at the edge that takes it. The sender
  // works in bursts; a new burst may open with an idle gap. The stall is
  // sampled at the falling edge, where it has settled, so the decision never
  // races the rising edge.
  task automatic offer(input pix_beat_t b);
    int   gap;
    logic stalled;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    items_sent++;
  endtask

  // Size register write: setup cycle, then access cycle until pready. Ends
  // with psel low so that back-to-back writes never share an edge.
  task automatic write_size(input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] value);
    logic ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (addr == WIDTH_ADDR) frame_w = effective_size(value[SIZE_W-1:0], MAX_WIDTH);
    else frame_h = effective_size(value[SIZE_W-1:0], MAX_HEIGHT);
  endtask

  // Stops sending and waits until every predicted mean has come out, then
  // lets the pipeline settle so that a register write finds the filter idle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A full frame followed by its width+1 drain beats.
  task automatic send_frame();
    repeat (frame_w * frame_h) offer(frame_pixel());
    repeat (frame_w + 1) offer(drain_beat());
  endtask

  // Noise: a short run of arbitrary beats that leaves the frame position
  // wherever it happens to end.
  task automatic send_noise();
    repeat ($urandom_range(1, 30)) begin
      offer(pixel_beat(PIX_W'($urandom), 1'($urandom_range(0, 1))));
    end
  endtask

  initial begin : stimulus
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One frame at the reset size, 24 by 7, with the receiver holding off
    // for a long stretch early on so the filter backs up.
    hold_req = 1'b1;
    send_frame();
    wait_quiet();

    // Three by two frame: white pixels, a black one, a pad beat inside the
    // frame, and a plain pixel among the drain beats.
    write_size(WIDTH_ADDR, 3);
    write_size(HEIGHT_ADDR, 2);
    offer(pixel_beat(8'hFF, 1'b0));
    offer(pixel_beat(8'hFF, 1'b0));
    offer(pixel_beat(8'hFF, 1'b0));
    offer(pixel_beat(8'h00, 1'b0));
    offer(pixel_beat(8'h4D, 1'b1));
    offer(pixel_beat(8'hFF, 1'b0));
    offer(pixel_beat(8'h00, 1'b1));
    offer(pixel_beat(8'hC8, 1'b0));
    offer(pixel_beat(8'hFF, 1'b1));
    offer(pixel_beat(8'hFF, 1'b1));
    wait_quiet();

    // Zero in both size registers means a one-pixel frame.
    write_size(WIDTH_ADDR, 0);
    write_size(HEIGHT_ADDR, 0);
    offer(pixel_beat(8'hFF, 1'b0));
    offer(pixel_beat(8'hFF, 1'b1));
    offer(pixel_beat(8'h09, 1'b1));
    wait_quiet();

    // A register write in the middle of a frame restarts it; the rows left
    // in the line stores must not leak into the new frame.
    write_size(WIDTH_ADDR, 2);
    write_size(HEIGHT_ADDR, 3);
    offer(pixel_beat(8'h01, 1'b0));
    offer(pixel_beat(8'h02, 1'b0));
    offer(pixel_beat(8'h03, 1'b0));
    wait_quiet();
    write_size(HEIGHT_ADDR, 2);
    repeat (4) offer(pixel_beat(8'hFF, 1'b0));
    repeat (3) offer(pixel_beat(8'h00, 1'b1));
    wait_quiet();

    // Widest row: every width bit set, clamped to the maximum. Only the
    // first row and a few drain beats are sent; the next write restarts.
    write_size(WIDTH_ADDR, 2047);
    write_size(HEIGHT_ADDR, 1);
    repeat (frame_w) offer(frame_pixel());
    repeat (6) offer(drain_beat());
    wait_quiet();
    write_size(WIDTH_ADDR, random_size(40));

    // Random phases: mostly well-formed frames with random content, some
    // noise, some size changes between phases and some frames back to back.
    while (items_sent < ITEMS_TOTAL) begin
      if ($urandom_range(0, 2) != 0) begin
        wait_quiet();
        if ($urandom_range(0, 1)) write_size(WIDTH_ADDR, random_size(40));
        if ($urandom_range(0, 1)) write_size(HEIGHT_ADDR, random_size(12));
      end
      repeat ($urandom_range(1, 3)) begin
        if (items_sent < ITEMS_TOTAL) begin
          if ($urandom_range(0, 7) == 0) send_noise();
          else send_frame();
        end
      end
    end

    wait_quiet();
    if (errors == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
